/* design/mjfa_pkg.sv */
// Shared types, constants and helper functions for the flip attitude generator.
`timescale 1ns / 1ps
package mjfa_pkg;

    localparam int QUAT_BITS    = 16;
    localparam int TICK_BITS    = 16;
    localparam int CNT_BITS     = TICK_BITS + 4;
    localparam int CORDIC_STEPS = 16;
    localparam int CI_BITS      = $clog2(CORDIC_STEPS);
    localparam int FRAC         = 24;
    localparam int DIV_BITS     = 64;
    localparam int DCNT_BITS    = $clog2(DIV_BITS);
    localparam int RATE_BITS    = 10;

    localparam logic signed [33:0] CORDIC_INIT = 34'sd652032874;
    localparam logic [22:0] TWO_PI_Q20 = 23'd6588397;
    localparam logic [RATE_BITS-1:0] RATE_RESET = 10'd100;
    localparam logic [28:0] POLY_TEN = 29'(10) << FRAC;
    localparam logic [24:0] ONE_Q24 = 25'(1) << FRAC;
    localparam logic [3:0] MUL_LAST = 4'd8;
    localparam logic [3:0] QUAT_LAST = 4'd7;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_CMD   = 2'd1,
        MODE_START = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        AXIS_X       = 2'd0,
        AXIS_Y       = 2'd1,
        AXIS_Z       = 2'd2,
        AXIS_INVALID = 2'd3
    } t_axis;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_USTART,
        ST_DIV_U,
        ST_MUL,
        ST_RSTART,
        ST_DIV_R,
        ST_CORDIC,
        ST_CFIN,
        ST_QUAT,
        ST_OUT
    } t_state;

    localparam logic [0:0] REG_TICK_RATE = 1'b0;

    function automatic logic [31:0] f_atan(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Start quaternion component that meets the sine term for output component i.
    function automatic logic [1:0] f_sn_idx(input logic [1:0] axis, input logic [1:0] i);
        logic [1:0] v;
        case (axis)
            AXIS_X: v = i ^ 2'd1;
            AXIS_Y: v = i ^ 2'd2;
            default: v = i ^ 2'd3;
        endcase
        return v;
    endfunction

    function automatic logic f_sn_neg(input logic [1:0] axis, input logic [1:0] i);
        logic v;
        case (axis)
            AXIS_X: v = (i == 2'd0) || (i == 2'd3);
            AXIS_Y: v = (i == 2'd0) || (i == 2'd1);
            default: v = (i == 2'd0) || (i == 2'd2);
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] f_rnd_sat(input logic signed [33:0] v);
        logic signed [33:0] t;
        logic signed [15:0] r;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32767) begin
            r = 16'sh7FFF;
        end else if (t < -34'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(t);
        end
        return r;
    endfunction

endpackage

/* design/min_jerk_flip_attitude_generator.sv */
// Top level of the minimum-jerk flip attitude generator with its sequencer and datapath.
// A tick during a flip that yields a word runs, from acceptance to o_valid, through
// two 64-step divisions on the one-bit-per-cycle divider, nine passes of the shared
// multiplier, sixteen CORDIC iterations and eight quaternion products. No new word is taken
// until the last one is through: one word is in work at a time.
// Synchronous active-low reset: no flip, identity start attitude, tick rate 100 Hz.
`timescale 1ns / 1ps
module min_jerk_flip_attitude_generator
    import mjfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_axis_select,
    input  logic signed [1:0]  i_turn_direction,
    input  logic [3:0]         i_turn_count,
    input  logic [15:0]        i_turn_ticks,
    input  logic signed [15:0] i_start_w,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_start_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_target_w,
    output logic signed [15:0] o_target_x,
    output logic signed [15:0] o_target_y,
    output logic signed [15:0] o_target_z,
    output logic signed [31:0] o_rate_x,
    output logic signed [31:0] o_rate_y,
    output logic signed [31:0] o_rate_z,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_state                      r_state, n_state;
    logic                        r_ovalid;
    logic                        r_active;
    logic [CNT_BITS-1:0]         r_elapsed, r_total;
    logic [1:0]                  r_axis;
    logic signed [1:0]           r_dir;
    logic [3:0]                  r_count;
    logic signed [QUAT_BITS-1:0] r_sq [4];
    logic [RATE_BITS-1:0]        r_rate;

    logic [3:0]                  r_step;
    logic [CI_BITS-1:0]          r_ci;
    logic [23:0]                 r_u, r_u2, r_u3, r_t;
    logic [27:0]                 r_s;
    logic [31:0]                 r_sc;
    logic [24:0]                 r_sdot;
    logic [28:0]                 r_a;
    logic [32:0]                 r_b;
    logic [63:0]                 r_num;
    logic signed [31:0]          r_w;
    logic signed [33:0]          r_x, r_y, r_z;
    logic                        r_flip;
    logic signed [15:0]          r_c, r_sn;
    logic signed [32:0]          r_acc;
    logic signed [15:0]          r_q [4];

    logic                        w_accept;
    logic                        w_wr;
    logic [CNT_BITS-1:0]         w_elapsed_n;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [DIV_BITS-1:0]         w_dividend;
    logic [DIV_BITS-1:0]         w_quot;
    logic signed [32:0]          w_ma, w_mb;
    logic signed [65:0]          w_prod;
    logic [27:0]                 w_poly;
    logic [1:0]                  w_qi;
    logic [1:0]                  w_sidx;
    logic                        w_sneg;
    logic signed [32:0]          w_psum;
    logic [35:0]                 w_mag;
    logic signed [31:0]          w_wsat;
    logic [31:0]                 w_ph_raw, w_ph, w_phf;
    logic                        w_pflip;
    logic signed [33:0]          w_dx, w_dy, w_at;
    logic                        w_load;

    assign w_accept    = i_valid && o_ready;
    assign pready      = 1'b1;
    assign w_wr        = psel && penable && pwrite && pready;
    assign prdata      = (paddr[2] == REG_TICK_RATE) ? 32'(r_rate) : 32'd0;
    assign w_elapsed_n = r_elapsed + 1'b1;
    assign w_load      = (r_state == ST_OUT) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && i_mode == MODE_TICK && r_active && w_elapsed_n < r_total) begin
                    n_state = ST_USTART;
                end
            end
            ST_USTART: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV_U;
            end
            ST_DIV_U: begin
                if (w_div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_step == MUL_LAST) begin
                    n_state = ST_RSTART;
                end
            end
            ST_RSTART: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV_R;
            end
            ST_DIV_R: begin
                if (w_div_done) begin
                    n_state = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (r_ci == CI_BITS'(CORDIC_STEPS - 1)) begin
                    n_state = ST_CFIN;
                end
            end
            ST_CFIN: begin
                n_state = ST_QUAT;
            end
            ST_QUAT: begin
                if (r_step == QUAT_LAST) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_dividend = (r_state == ST_USTART) ? (DIV_BITS'(r_elapsed) << FRAC) : r_num;

    mjfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_total),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_poly = 28'((29'(r_u2) * 29'd6) + POLY_TEN - (29'(r_u) * 29'd15));
    assign w_qi   = r_step[2:1];
    assign w_sidx = f_sn_idx(r_axis, w_qi);
    assign w_sneg = f_sn_neg(r_axis, w_qi);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == ST_QUAT) begin
            if (r_step[0]) begin
                w_ma = 33'(r_sq[w_sidx]);
                w_mb = 33'(r_sn);
            end else begin
                w_ma = 33'(r_sq[w_qi]);
                w_mb = 33'(r_c);
            end
        end else begin
            case (r_step)
                4'd0: begin w_ma = 33'(r_u);    w_mb = 33'(r_u);              end
                4'd1: begin w_ma = 33'(r_u2);   w_mb = 33'(r_u);              end
                4'd2: begin w_ma = 33'(r_u3);   w_mb = 33'(w_poly);           end
                4'd3: begin w_ma = 33'(r_s);    w_mb = 33'(r_count);          end
                4'd4: begin w_ma = 33'(r_u);    w_mb = 33'(ONE_Q24 - 25'(r_u)); end
                4'd5: begin w_ma = 33'(r_t);    w_mb = 33'(r_t);              end
                4'd6: begin w_ma = 33'(r_sdot); w_mb = 33'(r_count);          end
                4'd7: begin w_ma = 33'(r_rate); w_mb = 33'(TWO_PI_Q20);       end
                default: begin w_ma = 33'(r_a); w_mb = 33'(r_b[31:0]);        end
            endcase
        end
    end

    assign w_prod = w_ma * w_mb;
    assign w_psum = w_sneg ? (r_acc - w_prod[32:0]) : (r_acc + w_prod[32:0]);

    assign w_mag = 36'((w_quot + 64'd134217728) >> 28);
    always_comb begin
        if (r_dir == 2'sd0) begin
            w_wsat = '0;
        end else if (r_dir[1]) begin
            w_wsat = (w_mag >= 36'h080000000) ? 32'sh80000000 : -signed'(w_mag[31:0]);
        end else begin
            w_wsat = (w_mag > 36'h07FFFFFFF) ? 32'sh7FFFFFFF : signed'(w_mag[31:0]);
        end
    end

    assign w_ph_raw = {r_sc[24:0], 7'd0};
    assign w_ph     = (r_dir == 2'sd0) ? 32'd0 : (r_dir[1] ? (32'd0 - w_ph_raw) : w_ph_raw);
    assign w_pflip  = w_ph[31] != w_ph[30];
    assign w_phf    = w_pflip ? {~w_ph[31], w_ph[30:0]} : w_ph;

    assign w_dx = r_y >>> r_ci;
    assign w_dy = r_x >>> r_ci;
    assign w_at = 34'(f_atan(5'(r_ci)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_elapsed <= '0;
            r_total   <= '0;
            r_axis    <= AXIS_X;
            r_dir     <= '0;
            r_count   <= '0;
            r_sq[0]   <= QUAT_BITS'((1 << (QUAT_BITS - 1)) - 1);
            r_sq[1]   <= '0;
            r_sq[2]   <= '0;
            r_sq[3]   <= '0;
            r_rate    <= RATE_RESET;
            r_ovalid  <= 1'b0;
        end else begin
            if (w_wr && paddr[2] == REG_TICK_RATE) begin
                r_rate <= pwdata[RATE_BITS-1:0];
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (i_mode)
                            MODE_START: begin
                                if (!r_active) begin
                                    r_sq[0] <= i_start_w;
                                    r_sq[1] <= i_start_x;
                                    r_sq[2] <= i_start_y;
                                    r_sq[3] <= i_start_z;
                                end
                            end
                            MODE_CMD: begin
                                if (i_axis_select != AXIS_INVALID) begin
                                    r_axis    <= i_axis_select;
                                    r_dir     <= (i_turn_direction == -2'sd2) ? -2'sd1
                                                                              : i_turn_direction;
                                    r_count   <= i_turn_count;
                                    r_total   <= CNT_BITS'(i_turn_ticks[TICK_BITS-1:0])
                                                 * CNT_BITS'(i_turn_count);
                                    r_elapsed <= '0;
                                    r_active  <= 1'b1;
                                end
                            end
                            MODE_TICK: begin
                                if (r_active) begin
                                    r_elapsed <= w_elapsed_n;
                                    if (w_elapsed_n >= r_total) begin
                                        r_active <= 1'b0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV_U: begin
                    if (w_div_done) begin
                        r_u    <= w_quot[23:0];
                        r_step <= '0;
                    end
                end
                ST_MUL: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        4'd0: r_u2   <= w_prod[47:24];
                        4'd1: r_u3   <= w_prod[47:24];
                        4'd2: r_s    <= w_prod[51:24];
                        4'd3: r_sc   <= w_prod[31:0];
                        4'd4: r_t    <= w_prod[47:24];
                        4'd5: r_sdot <= 25'({w_prod[44:24], 5'd0} - {w_prod[44:24], 1'b0});
                        4'd6: r_a    <= w_prod[28:0];
                        4'd7: r_b    <= w_prod[32:0];
                        default: r_num <= w_prod[63:0] + (r_b[32] ? {3'd0, r_a, 32'd0} : 64'd0);
                    endcase
                end
                ST_DIV_R: begin
                    if (w_div_done) begin
                        r_w    <= w_wsat;
                        r_x    <= CORDIC_INIT;
                        r_y    <= '0;
                        r_z    <= 34'(signed'(w_phf));
                        r_flip <= w_pflip;
                        r_ci   <= '0;
                    end
                end
                ST_CORDIC: begin
                    r_ci <= r_ci + 1'b1;
                    if (!r_z[33]) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_at;
                    end
                end
                ST_CFIN: begin
                    r_c    <= f_rnd_sat(r_flip ? -r_x : r_x);
                    r_sn   <= f_rnd_sat(r_flip ? -r_y : r_y);
                    r_step <= '0;
                end
                ST_QUAT: begin
                    r_step <= r_step + 1'b1;
                    if (r_step[0]) begin
                        r_q[w_qi] <= f_rnd_sat(34'(w_psum));
                    end else begin
                        r_acc <= w_prod[32:0];
                    end
                end
                ST_OUT: begin
                    if (w_load) begin
                        o_target_w <= r_q[0];
                        o_target_x <= r_q[1];
                        o_target_y <= r_q[2];
                        o_target_z <= r_q[3];
                        o_rate_x   <= (r_axis == AXIS_X) ? r_w : 32'sd0;
                        o_rate_y   <= (r_axis == AXIS_Y) ? r_w : 32'sd0;
                        o_rate_z   <= (r_axis == AXIS_Z || r_axis == AXIS_INVALID)
                                      ? r_w : 32'sd0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovalid;

    a_fall_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_active) |-> $past(w_accept && i_mode == MODE_TICK))
        else $error("flip ended without an accepted tick");

    a_u_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_USTART) |-> (r_elapsed < r_total))
        else $error("division started with elapsed not below total");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_OUT))
        else $error("output word raised outside the output state");

    a_one_rate_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones({|o_rate_x, |o_rate_y, |o_rate_z}) <= 1))
        else $error("rate on more than one axis");

endmodule

/* design/mjfa_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module mjfa_div
    import mjfa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_dividend,
    input  logic [CNT_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [DIV_BITS-1:0] o_quot
);

    logic [DIV_BITS-1:0]  r_dq;
    logic [CNT_BITS-1:0]  r_rem;
    logic [DCNT_BITS-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS:0]    w_sh;
    logic [CNT_BITS:0]    w_diff;
    logic                 w_ge;

    assign w_sh   = {r_rem, r_dq[DIV_BITS-1]};
    assign w_ge   = w_sh >= {1'b0, i_divisor};
    assign w_diff = w_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dq   <= i_dividend;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dq  <= {r_dq[DIV_BITS-2:0], w_ge};
                r_rem <= w_ge ? w_diff[CNT_BITS-1:0] : w_sh[CNT_BITS-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_BITS'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dq;

endmodule
